// ===== sv/lbpc_pkg.sv =====
// shared types and constants for the lbp code 3x3 stream block
package lbpc_pkg;

  localparam int PIX_BITS    = 8;
  localparam int WIDTH_BITS  = 12;
  localparam int HEIGHT_BITS = 16;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int MIN_DIM     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;

  typedef logic [PIX_BITS-1:0] pixel_t;

  // one window column, top to bottom
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  // greater-than-centre flags of one column
  typedef struct packed {
    logic top;
    logic mid;
    logic bot;
  } column_gt_t;

  // position decisions for one pixel
  typedef struct packed {
    logic emit;
    logic eor;
    logic eof;
  } pos_flags_t;

endpackage

// ===== sv/lbp_code_3x3_stream.sv =====
// top level: streaming 8-neighbour local binary pattern over a 3x3 window
//
// in_*  : one 8-bit grayscale pixel per transfer in raster order; in_tuser
//         marks the first pixel of a frame and restarts the row/column count
// out_* : one 8-bit pattern code per centre pixel at least BORDER from every
//         edge; out_tlast marks the last code of a row, out_tuser the last
//         code of the frame
// cfg_* : image_width (index 0) and image_height (index 1), written while
//         the stream is idle; width is clamped to 3..MAX_WIDTH, height to >= 3
// throughput: one pixel per clock unless stalled, set by the single read port
//         and single write port of each line store, working side by side
// path:    the pixel completing a window, with the line store data read at its
//         transfer, sits in stage 1 where its code is formed; the code then
//         moves into the output register
// a pixel that opens no window (top rows, left columns, border) gives nothing
// stall: when out_tready is low with a code waiting, the whole pipe holds and
//         in_tready drops in the same cycle; nothing is lost or repeated
// reset: counters, stage-1 valid and output valid clear at once; window cells
//         and line stores are not cleared, each frame rewrites them first
module lbp_code_3x3_stream import lbpc_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int BORDER    = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // pixel stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [PIX_BITS-1:0]  in_tdata,   // [7:0] pixel
  input  logic                 in_tuser,   // [0] start_of_frame
  // code stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [PIX_BITS-1:0]  out_tdata,  // [7:0] pattern code
  output logic                 out_tlast,  // end_of_row
  output logic                 out_tuser,  // [0] end_of_frame
  // register writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_BITS-1:0]  cfg_wdata
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int NCELL = 2;

  logic [WIDTH_BITS-1:0]  width_r;
  logic [HEIGHT_BITS-1:0] height_r;

  logic       adv, in_acc;
  logic [CW-1:0] rd_addr;
  pos_flags_t pos_flags;

  // stage 1: line store data arrives, window shifts, code is formed
  logic       s1_v_r;
  pixel_t     s1_pix_r;
  pos_flags_t s1_flags_r;
  logic [CW-1:0] s1_addr_r;
  logic       s1_wr;
  logic       fwd_r;
  pixel_t     fwd_top_r, fwd_mid_r;
  pixel_t     up_q, md_q, top_eff, mid_eff;

  column_t    col_in [NCELL];
  column_t    col_q  [NCELL];
  column_gt_t gt_q   [NCELL];
  pixel_t     ctr;
  logic [PIX_BITS-1:0] code;

  logic       out_valid_r;
  pixel_t     out_code_r;
  logic       out_eor_r, out_eof_r;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[WIDTH_BITS-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // whole pipe moves when the output register is free or being emptied
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;

  lbpc_pos #(
    .MAX_WIDTH (MAX_WIDTH),
    .BORDER    (BORDER)
  ) u_pos (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .sof        (in_tuser),
    .width_cfg  (width_r),
    .height_cfg (height_r),
    .addr       (rd_addr),
    .flags      (pos_flags)
  );

  assign s1_wr = s1_v_r && adv;

  // the stage-1 write lands on the address read in the same cycle only after
  // a start of frame at column 0; forward the written values then
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r   <= in_tdata;
      s1_flags_r <= pos_flags;
      s1_addr_r  <= rd_addr;
      fwd_r      <= s1_wr && (s1_addr_r == rd_addr);
      fwd_top_r  <= mid_eff;
      fwd_mid_r  <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_acc;
    end
  end

  lbpc_ram #(
    .WIDTH (PIX_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk   (clk),
    .we    (s1_wr),
    .waddr (s1_addr_r),
    .wdata (mid_eff),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (up_q)
  );

  lbpc_ram #(
    .WIDTH (PIX_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_middle (
    .clk   (clk),
    .we    (s1_wr),
    .waddr (s1_addr_r),
    .wdata (s1_pix_r),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (md_q)
  );

  assign top_eff = fwd_r ? fwd_top_r : up_q;
  assign mid_eff = fwd_r ? fwd_mid_r : md_q;

  // window: cell 0 holds the previous column, cell 1 the one before it
  assign col_in[0] = '{top: top_eff, mid: mid_eff, bot: s1_pix_r};
  assign col_in[1] = col_q[0];
  assign ctr       = col_q[0].mid;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    lbpc_cell u_cell (
      .clk   (clk),
      .en    (s1_wr),
      .col_i (col_in[i]),
      .ctr   (ctr),
      .col_o (col_q[i]),
      .gt_o  (gt_q[i])
    );
  end

  // clockwise from top-left, ending at left
  assign code = {gt_q[1].top, gt_q[0].top, (top_eff > ctr), (mid_eff > ctr),
                 (s1_pix_r > ctr), gt_q[0].bot, gt_q[1].bot, gt_q[1].mid};

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_v_r && s1_flags_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_code_r <= code;
      out_eor_r  <= s1_flags_r.eor;
      out_eof_r  <= s1_flags_r.eof;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_code_r;
  assign out_tlast  = out_eor_r;
  assign out_tuser  = out_eof_r;

`ifndef ASSERT_OFF
  // the frame's last code is always the last code of a row
  a_eof_is_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tuser |-> out_tlast)
    else $error("end of frame without end of row");

  // a code only appears after a pixel sat in stage 1
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_v_r))
    else $error("output valid without a stage-1 pixel");

  // a stalled stage-1 pixel is kept
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !adv |=> s1_v_r)
    else $error("stage-1 pixel dropped under stall");

  // forwarding only follows a pixel that was written ahead of this one
  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && fwd_r |-> $past(s1_v_r))
    else $error("line store forward without a preceding write");
`endif

endmodule

// ===== sv/lbpc_ram.sv =====
// generic single-write, single-read ram with registered read data (read-first)
module lbpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/lbpc_cell.sv =====
// one window column cell: holds a column, compares it against the centre
module lbpc_cell import lbpc_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  column_t    col_i,
  input  pixel_t     ctr,
  output column_t    col_o,
  output column_gt_t gt_o
);

  column_t col_r;

  always_ff @(posedge clk) begin
    if (en) begin
      col_r <= col_i;
    end
  end

  assign col_o    = col_r;
  assign gt_o.top = (col_r.top > ctr);
  assign gt_o.mid = (col_r.mid > ctr);
  assign gt_o.bot = (col_r.bot > ctr);

endmodule

// ===== sv/lbpc_pos.sv =====
// column and row counters, border test and end-of-row / end-of-frame marks
module lbpc_pos import lbpc_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int BORDER    = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  logic                         sof,
  input  logic [WIDTH_BITS-1:0]        width_cfg,
  input  logic [HEIGHT_BITS-1:0]       height_cfg,
  output logic [$clog2(MAX_WIDTH)-1:0] addr,
  output pos_flags_t                   flags
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int EW = (WW > WIDTH_BITS) ? WW : WIDTH_BITS;
  localparam int RW = HEIGHT_BITS + 2;

  localparam logic [EW-1:0] MAXW    = EW'(MAX_WIDTH);
  localparam logic [EW-1:0] MINW    = EW'(MIN_DIM);
  localparam logic [EW:0]   BORD_C  = (EW + 1)'(BORDER);
  localparam logic [EW-1:0] LOW_C   = EW'(BORDER + 1);
  localparam logic [RW-1:0] BORD_R  = RW'(BORDER);
  localparam logic [RW-1:0] LOW_R   = RW'(BORDER + 1);

  logic [CW-1:0]          col_r, col_nxt;
  logic [HEIGHT_BITS-1:0] row_r, row_nxt;

  logic [EW-1:0]          w_eff;
  logic [HEIGHT_BITS-1:0] h_eff;
  logic [EW-1:0]          cs;
  logic [RW-1:0]          rs;
  logic [EW:0]            c_inc;
  logic [RW-1:0]          r_inc;
  logic                   col_ok, row_ok;

  always_comb begin
    w_eff = EW'(width_cfg);
    if (w_eff < MINW) begin
      w_eff = MINW;
    end else if (w_eff > MAXW) begin
      w_eff = MAXW;
    end
    h_eff = (height_cfg < HEIGHT_BITS'(MIN_DIM)) ? HEIGHT_BITS'(MIN_DIM) : height_cfg;
  end

  // position of this pixel, with the wraps for start of frame and shrunk sizes
  always_comb begin
    cs = sof ? '0 : EW'(col_r);
    rs = sof ? '0 : RW'(row_r);
    if (cs >= w_eff) begin
      cs = '0;
      rs = rs + RW'(1);
    end
    if (rs >= RW'(h_eff)) begin
      rs = '0;
    end
  end

  assign addr = cs[CW-1:0];

  // centre sits one row up and one column left of this pixel
  assign col_ok = (cs >= LOW_C) && ((EW + 1)'(cs) + BORD_C <= (EW + 1)'(w_eff));
  assign row_ok = (rs >= LOW_R) && (rs + BORD_R <= RW'(h_eff));

  assign flags.emit = col_ok && row_ok;
  assign flags.eor  = ((EW + 1)'(cs) + BORD_C == (EW + 1)'(w_eff));
  assign flags.eof  = flags.eor && (rs + BORD_R == RW'(h_eff));

  always_comb begin
    c_inc   = (EW + 1)'(cs) + (EW + 1)'(1);
    r_inc   = rs + RW'(1);
    col_nxt = CW'(c_inc);
    row_nxt = rs[HEIGHT_BITS-1:0];
    if (c_inc >= (EW + 1)'(w_eff)) begin
      col_nxt = '0;
      row_nxt = (r_inc >= RW'(h_eff)) ? '0 : r_inc[HEIGHT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== tb/sv/lbp_code_3x3_stream_test.sv =====
// self-checking stream testbench for the 3x3 local binary pattern block
module lbp_code_3x3_stream_test;
  import lbpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W          = 2048;
  localparam int BORDER_PX      = 1;
  localparam int CLK_HALF_NS    = 4;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 6;     // margin for the pipe to settle
  localparam int RX_HOLD_CYCLES = 300;   // long enough to back the pipe up
  localparam int ITEM_TARGET    = 1200;
  localparam longint RUN_LIMIT_NS = 20_000_000;

  // one pixel transfer as queued for the driver
  typedef struct packed {
    pixel_t pixel;
    logic   sof;
  } pixel_item_t;

  // one predicted code transfer
  typedef struct packed {
    pixel_t code;
    logic   eor;
    logic   eof;
  } code_item_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [PIX_BITS-1:0]  in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [PIX_BITS-1:0]  out_tdata;
  logic                 out_tlast;
  logic                 out_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_BITS-1:0]  cfg_wdata = '0;

  lbp_code_3x3_stream u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // stimulus and scoreboard storage
  pixel_item_t pixel_feed[$];
  code_item_t  pending_codes[$];
  int          mismatch_count = 0;

  // handshake bookkeeping, updated at the rising edge
  logic in_took = 1'b0;
  logic out_took = 1'b0;
  int   tx_wait = 0;
  int   rx_wait = 0;
  logic no_idle = 1'b0;   // a stretch with no gaps on either side
  logic rx_hold = 1'b0;   // long receiver hold-off in progress
  event hold_go;

  // predictor copy of the registers and the block state
  logic [WIDTH_BITS-1:0]  reg_width = WIDTH_RESET;
  logic [HEIGHT_BITS-1:0] reg_height = HEIGHT_RESET;
  pixel_t store_upper [MAX_W];
  pixel_t store_middle [MAX_W];
  pixel_t win_px [6];     // 0..2 previous column top..bottom, 3..5 the one before
  int     col_pos = 0;
  int     row_pos = 0;

  initial begin : clock_gen
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("lbp_code_3x3_stream_test NOT OK");
    $finish;
  end

  // clamped image sizes as the block sees them
  function automatic int eff_cols();
    int w = reg_width;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int eff_rows();
    int h = reg_height;
    if (h < MIN_DIM) h = MIN_DIM;
    return h;
  endfunction

  // idle cycles before the next transfer on either side
  function automatic int pick_gap();
    if (no_idle) return 0;
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 17);
      1: return $urandom_range(0, 2);
      default: return 0;
    endcase
  endfunction

  // pixel values biased toward the extremes and toward ties
  function automatic pixel_t rand_pixel();
    case ($urandom_range(0, 3))
      0: return pixel_t'($urandom_range(0, 3));
      1: return pixel_t'(8'hFF - $urandom_range(0, 3));
      default: return pixel_t'($urandom_range(0, 255));
    endcase
  endfunction

  // advance the window by one accepted pixel and queue the code it completes
  function automatic void predict_pixel(pixel_t px, logic sof);
    int w, h, c, r;
    pixel_t above, middle, ctr;
    code_item_t res;
    w = eff_cols();
    h = eff_rows();
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    // counters left past the edge by a register change wrap here
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    above  = store_upper[c];
    middle = store_middle[c];
    // centre sits one row up and one column left of this pixel
    if (r >= 2 && c >= 2 && r - 1 >= BORDER_PX && r + BORDER_PX <= h &&
        c - 1 >= BORDER_PX && c + BORDER_PX <= w) begin
      ctr = win_px[1];
      res.code = {win_px[3] > ctr, win_px[0] > ctr, above > ctr, middle > ctr,
                  px > ctr, win_px[2] > ctr, win_px[5] > ctr, win_px[4] > ctr};
      res.eor = (c + BORDER_PX == w);
      res.eof = res.eor && (r + BORDER_PX == h);
      pending_codes.push_back(res);
    end
    win_px[3] = win_px[0];
    win_px[4] = win_px[1];
    win_px[5] = win_px[2];
    win_px[0] = above;
    win_px[1] = middle;
    win_px[2] = px;
    store_upper[c]  = middle;
    store_middle[c] = px;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  // input and output monitor: every transfer is seen at the rising edge
  always @(posedge clk) begin
    code_item_t want;
    in_took  <= rst_n && in_tvalid && in_tready;
    out_took <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) predict_pixel(in_tdata, in_tuser);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_codes.size() == 0) begin
        $error("code transfer with none expected: pattern_code %02h", out_tdata);
        mismatch_count++;
      end else begin
        want = pending_codes.pop_front();
        if (out_tdata !== want.code) begin
          $error("pattern_code expected %02h actual %02h", want.code, out_tdata);
          mismatch_count++;
        end
        if (out_tlast !== want.eor) begin
          $error("end_of_row expected %0b actual %0b", want.eor, out_tlast);
          mismatch_count++;
        end
        if (out_tuser !== want.eof) begin
          $error("end_of_frame expected %0b actual %0b", want.eof, out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // pixel driver: holds a transfer until taken, then waits a drawn gap
  always @(negedge clk) begin
    pixel_item_t item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_took) tx_wait = pick_gap();
      if (!in_tvalid || in_took) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_tvalid <= 1'b0;
          in_tdata  <= PIX_BITS'($urandom);
        end else if (pixel_feed.size() != 0) begin
          item = pixel_feed.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= item.pixel;
          in_tuser  <= item.sof;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // code receiver: random stalls after each transfer, plus the long hold-off
  always @(negedge clk) begin
    if (out_took) rx_wait = pick_gap();
    if (rx_hold) begin
      out_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // long hold-off, counted here so the sender keeps offering meanwhile
  initial begin : rx_hold_off
    forever begin
      @(hold_go);
      @(negedge clk);
      rx_hold <= 1'b1;
      repeat (RX_HOLD_CYCLES) @(negedge clk);
      rx_hold <= 1'b0;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx == CFG_IMAGE_WIDTH) reg_width = val[WIDTH_BITS-1:0];
    else reg_height = val[HEIGHT_BITS-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= CFG_BITS'($urandom);
  endtask

  // sender pauses until every code is back and the pipe has settled
  task automatic drain_stream();
    while (pixel_feed.size() != 0 || in_tvalid || pending_codes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_pixel(pixel_t px, logic sof);
    pixel_item_t item;
    item.pixel = px;
    item.sof   = sof;
    pixel_feed.push_back(item);
  endtask

  // one 3x3 frame: rim value everywhere, centre and one odd neighbour apart
  task automatic push_3x3(logic sof, pixel_t ctr, pixel_t rim, int odd_k,
                          pixel_t odd_px);
    for (int k = 0; k < 9; k++)
      push_pixel(k == 4 ? ctr : (k == odd_k ? odd_px : rim), sof && k == 0);
  endtask

  // new sizes, then a run of frames; widening always restarts the frame
  task automatic random_phase(inout int n_sent);
    logic [CFG_BITS-1:0] wv, hv;
    int old_w, w, h, frame_px, n;
    logic framed, sof;
    old_w = eff_cols();
    case ($urandom_range(0, 9))
      0: wv = CFG_BITS'($urandom_range(0, 2));
      1: wv = CFG_BITS'($urandom_range(13, 48));
      2: wv = 16'hF000 | CFG_BITS'($urandom_range(3, 12));  // upper bits dropped
      default: wv = CFG_BITS'($urandom_range(3, 12));
    endcase
    case ($urandom_range(0, 7))
      0: hv = CFG_BITS'($urandom_range(0, 2));
      1: hv = CFG_BITS'($urandom_range(9, 30));
      default: hv = CFG_BITS'($urandom_range(3, 8));
    endcase
    if ($urandom_range(0, 3) != 0) write_reg(CFG_IMAGE_WIDTH, wv);
    if ($urandom_range(0, 3) != 0) write_reg(CFG_IMAGE_HEIGHT, hv);
    w = eff_cols();
    h = eff_rows();
    frame_px = w * h;
    if (frame_px <= 120) n = frame_px * $urandom_range(1, 3) + $urandom_range(0, w);
    else n = w * $urandom_range(3, 5) + $urandom_range(0, w);
    // without a restart the counters carry on from mid-frame
    framed = (w > old_w) || ($urandom_range(0, 1) == 1);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      sof = (framed && i % frame_px == 0 && (i == 0 || $urandom_range(0, 3) != 0)) ||
            ($urandom_range(0, 199) == 0);
      push_pixel(rand_pixel(), sof);
    end
    n_sent += n;
    drain_stream();
  endtask

  initial begin : stimulus
    int n_sent;
    n_sent = 0;
    for (int i = 0; i < MAX_W; i++) begin
      store_upper[i]  = '0;
      store_middle[i] = '0;
    end
    for (int i = 0; i < 6; i++) win_px[i] = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // directed: smallest image from out-of-range sizes
    write_reg(CFG_IMAGE_WIDTH, 16'hF000);
    write_reg(CFG_IMAGE_HEIGHT, 16'h0001);
    push_3x3(1'b1, 8'h00, 8'hFF, 4, 8'h00);   // every neighbour greater
    push_3x3(1'b0, 8'hFF, 8'h00, 4, 8'hFF);   // overrun into a new frame, none greater
    push_3x3(1'b1, 8'd100, 8'd100, 2, 8'd101); // ties do not count, one neighbour does
    n_sent += 3 * 9;
    drain_stream();

    // receiver holds off while the sender keeps offering
    write_reg(CFG_IMAGE_WIDTH, 16'd6);
    write_reg(CFG_IMAGE_HEIGHT, 16'd5);
    no_idle = 1'b1;
    -> hold_go;
    for (int i = 0; i < 200; i++) push_pixel(rand_pixel(), i == 0);
    n_sent += 200;
    drain_stream();

    // tallest frame, only its first rows
    write_reg(CFG_IMAGE_WIDTH, 16'd5);
    write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
    no_idle = 1'b0;
    for (int i = 0; i < 60; i++) push_pixel(rand_pixel(), i == 0);
    n_sent += 60;
    drain_stream();

    while (n_sent < ITEM_TARGET) random_phase(n_sent);

    drain_stream();
    if (mismatch_count == 0) begin
      $display("lbp_code_3x3_stream_test OK");
    end else begin
      $display("lbp_code_3x3_stream_test NOT OK");
    end
    $finish;
  end

endmodule
